// ===== rtl/vjal_pkg.sv =====
// Shared types, constants and helper functions for the velocity jerk/accel limiter.
package vjal_pkg;

  localparam int VALUE_W   = 32;              // velocity, limit and ratio width
  localparam int DT_W      = 32;              // time step width, unsigned Q8.24
  localparam int DT_FRAC   = 24;              // fraction bits of the time step
  localparam int INT_W     = 64;              // internal velocity width
  localparam int MAG_W     = 63;              // magnitude width, up to 2^62
  localparam int DIFF_W    = VALUE_W + 2;     // second difference of three velocities
  localparam int DT2_W     = 2 * DT_W - (DT_FRAC - 1);  // 2*dt^2, unsigned Q.24
  localparam int CFG_IDX_W = 3;

  // Bit positions in limit_enables
  localparam int ENA_VEL  = 0;
  localparam int ENA_ACC  = 1;
  localparam int ENA_JERK = 2;
  localparam int ENA_W    = 3;

  localparam logic [INT_W-1:0]        BIG_MAG = 64'h4000_0000_0000_0000;
  localparam logic signed [INT_W-1:0] BIG_POS = 64'sh4000_0000_0000_0000;
  localparam logic signed [INT_W-1:0] BIG_NEG = -BIG_POS;

  localparam logic signed [INT_W-1:0] OUT_MAX = (INT_W'(1) << (VALUE_W - 1)) - INT_W'(1);
  localparam logic signed [INT_W-1:0] OUT_MIN = ~OUT_MAX;

  localparam logic [VALUE_W-1:0] RATIO_LIM = {1'b1, {(VALUE_W - 1){1'b0}}};
  localparam logic [VALUE_W-1:0] RATIO_MAX = {1'b0, {(VALUE_W - 1){1'b1}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LIMIT_ENABLES,
    REG_VELOCITY_MIN,
    REG_VELOCITY_MAX,
    REG_ACCEL_MIN,
    REG_ACCEL_MAX,
    REG_JERK_MIN,
    REG_JERK_MAX
  } cfg_reg_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] cmd_velocity;
    logic signed [VALUE_W-1:0] last_velocity;
    logic signed [VALUE_W-1:0] older_velocity;
    logic [DT_W-1:0]           time_step;
  } vjal_in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] limited_velocity;
    logic signed [VALUE_W-1:0] scale_ratio;
  } vjal_out_t;

  // Sign and overflow flags that travel with the divider operands
  typedef struct packed {
    logic neg;
    logic zero;
    logic ovf;
  } div_flags_t;

  function automatic logic signed [INT_W-1:0] ext_val(input logic [VALUE_W-1:0] a);
    return {{(INT_W - VALUE_W){a[VALUE_W-1]}}, a};
  endfunction

  function automatic logic signed [INT_W-1:0] ext_diff(input logic [DIFF_W-1:0] a);
    return {{(INT_W - DIFF_W){a[DIFF_W-1]}}, a};
  endfunction

  // min(max(lo, x), hi): hi wins when the bounds are inverted
  function automatic logic signed [INT_W-1:0] clamp_s(input logic signed [INT_W-1:0] x,
                                                      input logic signed [INT_W-1:0] lo,
                                                      input logic signed [INT_W-1:0] hi);
    if ((lo < hi) && (x < hi)) begin
      return (x > lo) ? x : lo;
    end
    return hi;
  endfunction

  function automatic logic signed [INT_W-1:0] sat_big(input logic signed [INT_W-1:0] x);
    if (x > BIG_POS) begin
      return BIG_POS;
    end
    if (x < BIG_NEG) begin
      return BIG_NEG;
    end
    return x;
  endfunction

endpackage

// ===== rtl/vjal_scale_mul.sv =====
// Three-stage bound scaler: |bound| * op >> 24, saturated to 2^62, sign restored.
module vjal_scale_mul
  import vjal_pkg::*;
#(
  parameter int OP_W = 32
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [VALUE_W-1:0]        bound,
  input  logic [OP_W-1:0]           op,
  output logic signed [INT_W-1:0]  scaled
);

  localparam int LO_W  = OP_W / 2;
  localparam int HI_W  = OP_W - LO_W;
  localparam int PW    = VALUE_W + OP_W;
  localparam int SH_W  = PW - DT_FRAC;
  localparam int CMP_W = (SH_W > INT_W) ? SH_W : INT_W;

  logic [VALUE_W-1:0]      mag_a;
  logic                    neg_a;
  logic [VALUE_W+LO_W-1:0] p_lo;
  logic [VALUE_W+HI_W-1:0] p_hi;
  logic [PW-1:0]           sum_b;
  logic                    neg_b;
  logic [SH_W-1:0]         sh;
  logic [CMP_W-1:0]        wide_c;
  logic [MAG_W-1:0]        mag_c;

  assign mag_a = bound[VALUE_W-1] ? (VALUE_W'(0) - bound) : bound;

  // partial products over the two halves of the operand
  always_ff @(posedge clk) begin
    if (en) begin
      neg_a <= bound[VALUE_W-1];
      p_lo  <= (VALUE_W + LO_W)'(mag_a) * (VALUE_W + LO_W)'(op[LO_W-1:0]);
      p_hi  <= (VALUE_W + HI_W)'(mag_a) * (VALUE_W + HI_W)'(op[OP_W-1:LO_W]);
    end
  end

  assign sum_b = (PW'(p_hi) << LO_W) + PW'(p_lo);

  always_ff @(posedge clk) begin
    if (en) begin
      neg_b <= neg_a;
      sh    <= sum_b[PW-1:DT_FRAC];
    end
  end

  assign wide_c = CMP_W'(sh);
  assign mag_c  = (wide_c > CMP_W'(BIG_MAG)) ? BIG_MAG[MAG_W-1:0] : wide_c[MAG_W-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      scaled <= neg_b ? (INT_W'(0) - INT_W'(mag_c)) : INT_W'(mag_c);
    end
  end

endmodule

// ===== rtl/vjal_ratio_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, overflow flagged up front.
module vjal_ratio_div
  import vjal_pkg::*;
#(
  parameter int NUM_W  = 79,
  parameter int DEN_W  = 32,
  parameter int SIDE_W = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  div_flags_t        in_flags,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [DEN_W-1:0]  quot,
  output div_flags_t        out_flags,
  output logic [SIDE_W-1:0] side_out
);

  localparam int HI_W  = NUM_W - DEN_W;
  localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

  logic              vld  [0:DEN_W];
  logic [DEN_W-1:0]  rem  [0:DEN_W];
  logic [DEN_W-1:0]  lo   [0:DEN_W];
  logic [DEN_W-1:0]  quo  [0:DEN_W];
  logic [DEN_W-1:0]  dn   [0:DEN_W];
  div_flags_t        flg  [0:DEN_W];
  logic [SIDE_W-1:0] side [0:DEN_W];

  logic [CMP_W-1:0] hi_ext;
  div_flags_t       flags0;

  assign hi_ext = CMP_W'(num[NUM_W-1:DEN_W]);

  // quotient reaches 2^DEN_W exactly when the upper dividend is not below the divisor
  always_comb begin
    flags0      = in_flags;
    flags0.ovf  = (hi_ext >= CMP_W'(den));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= hi_ext[DEN_W-1:0];
      lo[0]   <= num[DEN_W-1:0];
      quo[0]  <= '0;
      dn[0]   <= den;
      flg[0]  <= flags0;
      side[0] <= side_in;
    end
  end

  for (genvar k = 1; k <= DEN_W; k++) begin : g_step
    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           take;

    assign trial = {rem[k-1], lo[k-1][DEN_W-1]};
    assign diff  = trial - {1'b0, dn[k-1]};
    assign take  = (trial >= {1'b0, dn[k-1]});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]  <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        lo[k]   <= lo[k-1] << 1;
        quo[k]  <= {quo[k-1][DEN_W-2:0], take};
        dn[k]   <= dn[k-1];
        flg[k]  <= flg[k-1];
        side[k] <= side[k-1];
      end
    end
  end

  assign out_valid = vld[DEN_W];
  assign quot      = quo[DEN_W];
  assign out_flags = flg[DEN_W];
  assign side_out  = side[DEN_W];

endmodule

// ===== rtl/velocity_jerk_accel_limiter_unit.sv =====
// Top level of the velocity limiter: jerk, acceleration and velocity clamps plus ratio.
//
//   channel  | direction | handshake           | payload
//   ---------+-----------+---------------------+------------------------------------
//   cmd      | in        | cmd_valid/cmd_stall | vjal_in_t  (command, history, dt)
//   res      | out       | res_valid/res_stall | vjal_out_t (limited velocity, ratio)
//   cfg      | in        | cfg_valid/cfg_ready | cfg_index, cfg_data (register write)
//
// One item enters per clock while cmd_stall is low. An item passes ten stages of scaling
// and clamping, then the ratio divider, which spends one pipeline stage per quotient bit,
// then the output register.
// rst is synchronous and active high: it empties the pipeline and clears the config registers.
// A stalled result sits in the output register while one more item drains into a skid
// register; only with the skid register full does cmd_stall rise and the pipeline hold.
module velocity_jerk_accel_limiter_unit
  import vjal_pkg::*;
#(
  parameter int FRAC_BITS = 16   // fraction bits of velocities and ratio, 8 to 24
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_stall,
  input  vjal_in_t             cmd_data,
  output logic                 res_valid,
  input  logic                 res_stall,
  output vjal_out_t            res_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VALUE_W-1:0]   cfg_data
);

  localparam int NUM_W = MAG_W + FRAC_BITS;
  localparam logic [VALUE_W-1:0] RATIO_ONE = VALUE_W'(1) << FRAC_BITS;

  // Front stages carry the command and the jerk terms while the bounds are scaled
  typedef struct packed {
    logic [VALUE_W-1:0] cmd;
    logic [VALUE_W-1:0] v0;
    logic [DIFF_W-1:0]  jx;    // cmd - 2*last + older
    logic [DIFF_W-1:0]  jb;    // 2*last - older
    logic [DT_W-1:0]    dt;
  } front_t;

  // Back stages carry the running velocity (or the clamped difference) in x
  typedef struct packed {
    logic [VALUE_W-1:0]       cmd;
    logic [VALUE_W-1:0]       v0;
    logic [DIFF_W-1:0]        jb;
    logic signed [INT_W-1:0]  x;
  } back_t;

  // Configuration registers
  logic [ENA_W-1:0]   limit_enables;
  logic [VALUE_W-1:0] velocity_min;
  logic [VALUE_W-1:0] velocity_max;
  logic [VALUE_W-1:0] accel_min;
  logic [VALUE_W-1:0] accel_max;
  logic [VALUE_W-1:0] jerk_min;
  logic [VALUE_W-1:0] jerk_max;

  // Pipeline
  logic                    adv;
  logic                    vld [1:10];
  front_t                  fr  [1:4];
  back_t                   bk  [5:9];
  logic [2*DT_W-1:0]       dtsq;
  logic [2*DT_W-1:0]       dtsq_in;
  logic [DIFF_W-1:0]       jx_in;
  logic [DIFF_W-1:0]       jb_in;
  logic signed [INT_W-1:0] j_lo;
  logic signed [INT_W-1:0] j_hi;
  logic signed [INT_W-1:0] a_lo;
  logic signed [INT_W-1:0] a_hi;

  // Divider operands
  logic [MAG_W-1:0]        d_mag;
  logic [VALUE_W-1:0]      d_den;
  div_flags_t              d_flags;
  logic [VALUE_W-1:0]      d_lv;

  logic                    div_valid;
  logic [VALUE_W-1:0]      div_quot;
  div_flags_t              div_flags;
  logic [VALUE_W-1:0]      div_lv;

  // Output register and skid register
  vjal_out_t               result;
  logic                    skid_valid;
  vjal_out_t               skid_data;
  logic                    res_take;
  logic                    pipe_emit;

  // ---------------------------------------------------------------------------------
  // Configuration writes: always ready; unknown indexes are dropped.
  // ---------------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit_enables <= '0;
      velocity_min  <= '0;
      velocity_max  <= '0;
      accel_min     <= '0;
      accel_max     <= '0;
      jerk_min      <= '0;
      jerk_max      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_LIMIT_ENABLES: limit_enables <= cfg_data[ENA_W-1:0];
        REG_VELOCITY_MIN:  velocity_min  <= cfg_data;
        REG_VELOCITY_MAX:  velocity_max  <= cfg_data;
        REG_ACCEL_MIN:     accel_min     <= cfg_data;
        REG_ACCEL_MAX:     accel_max     <= cfg_data;
        REG_JERK_MIN:      jerk_min      <= cfg_data;
        REG_JERK_MAX:      jerk_max      <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------------
  // Flow control: every stage advances together unless the skid register is occupied.
  // ---------------------------------------------------------------------------------
  assign adv       = !skid_valid;
  assign cmd_stall = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= 10; i++) begin
        vld[i] <= 1'b0;
      end
    end else if (adv) begin
      vld[1] <= cmd_valid;
      for (int i = 2; i <= 10; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  // ---------------------------------------------------------------------------------
  // Stage 1: take the item, form the jerk terms and dt squared.
  // ---------------------------------------------------------------------------------
  always_comb begin
    jx_in = DIFF_W'(ext_val(cmd_data.cmd_velocity))
          - (DIFF_W'(ext_val(cmd_data.last_velocity)) << 1)
          + DIFF_W'(ext_val(cmd_data.older_velocity));
    jb_in = (DIFF_W'(ext_val(cmd_data.last_velocity)) << 1)
          - DIFF_W'(ext_val(cmd_data.older_velocity));
    dtsq_in = (2 * DT_W)'(cmd_data.time_step) * (2 * DT_W)'(cmd_data.time_step);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fr[1].cmd <= cmd_data.cmd_velocity;
      fr[1].v0  <= cmd_data.last_velocity;
      fr[1].jx  <= jx_in;
      fr[1].jb  <= jb_in;
      fr[1].dt  <= cmd_data.time_step;
      dtsq      <= dtsq_in;
      for (int i = 2; i <= 4; i++) begin
        fr[i] <= fr[i-1];
      end
    end
  end

  // ---------------------------------------------------------------------------------
  // Stages 2 to 4: scale the jerk bounds by 2*dt^2 = dt^2 >> 23.
  // Stages 4 to 6: scale the acceleration bounds by dt, started two stages later so
  // that they land where the acceleration clamp needs them.
  // ---------------------------------------------------------------------------------
  vjal_scale_mul #(.OP_W(DT2_W)) u_jerk_lo (
    .clk    (clk),
    .en     (adv),
    .bound  (jerk_min),
    .op     (dtsq[2*DT_W-1:DT_FRAC-1]),
    .scaled (j_lo)
  );

  vjal_scale_mul #(.OP_W(DT2_W)) u_jerk_hi (
    .clk    (clk),
    .en     (adv),
    .bound  (jerk_max),
    .op     (dtsq[2*DT_W-1:DT_FRAC-1]),
    .scaled (j_hi)
  );

  vjal_scale_mul #(.OP_W(DT_W)) u_acc_lo (
    .clk    (clk),
    .en     (adv),
    .bound  (accel_min),
    .op     (fr[3].dt),
    .scaled (a_lo)
  );

  vjal_scale_mul #(.OP_W(DT_W)) u_acc_hi (
    .clk    (clk),
    .en     (adv),
    .bound  (accel_max),
    .op     (fr[3].dt),
    .scaled (a_hi)
  );

  // ---------------------------------------------------------------------------------
  // Stages 5 to 9: jerk clamp, jerk sum, acceleration clamp, acceleration sum,
  // velocity clamp. A disabled limit passes the running velocity unchanged.
  // ---------------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 5: clamp the change in velocity difference
      bk[5].cmd <= fr[4].cmd;
      bk[5].v0  <= fr[4].v0;
      bk[5].jb  <= fr[4].jb;
      bk[5].x   <= clamp_s(ext_diff(fr[4].jx), j_lo, j_hi);

      // stage 6: rebuild the velocity from the last difference, or start from the command
      bk[6].cmd <= bk[5].cmd;
      bk[6].v0  <= bk[5].v0;
      bk[6].jb  <= bk[5].jb;
      bk[6].x   <= limit_enables[ENA_JERK] ? sat_big(ext_diff(bk[5].jb) + bk[5].x)
                                           : ext_val(bk[5].cmd);

      // stage 7: clamp the change against the last velocity
      bk[7].cmd <= bk[6].cmd;
      bk[7].v0  <= bk[6].v0;
      bk[7].jb  <= bk[6].jb;
      bk[7].x   <= limit_enables[ENA_ACC] ? clamp_s(bk[6].x - ext_val(bk[6].v0), a_lo, a_hi)
                                          : bk[6].x;

      // stage 8: add the clamped change back
      bk[8].cmd <= bk[7].cmd;
      bk[8].v0  <= bk[7].v0;
      bk[8].jb  <= bk[7].jb;
      bk[8].x   <= limit_enables[ENA_ACC] ? sat_big(ext_val(bk[7].v0) + bk[7].x) : bk[7].x;

      // stage 9: absolute velocity bounds
      bk[9].cmd <= bk[8].cmd;
      bk[9].v0  <= bk[8].v0;
      bk[9].jb  <= bk[8].jb;
      bk[9].x   <= limit_enables[ENA_VEL]
                   ? clamp_s(bk[8].x, ext_val(velocity_min), ext_val(velocity_max))
                   : bk[8].x;
    end
  end

  // ---------------------------------------------------------------------------------
  // Stage 10: split into sign and magnitude for the ratio, saturate the output velocity.
  // ---------------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (adv) begin
      d_mag        <= bk[9].x[INT_W-1] ? MAG_W'(INT_W'(0) - bk[9].x) : bk[9].x[MAG_W-1:0];
      d_den        <= bk[9].cmd[VALUE_W-1] ? (VALUE_W'(0) - bk[9].cmd) : bk[9].cmd;
      d_flags.neg  <= bk[9].x[INT_W-1] ^ bk[9].cmd[VALUE_W-1];
      d_flags.zero <= (bk[9].cmd == '0);
      d_flags.ovf  <= 1'b0;
      if (bk[9].x > OUT_MAX) begin
        d_lv <= OUT_MAX[VALUE_W-1:0];
      end else if (bk[9].x < OUT_MIN) begin
        d_lv <= OUT_MIN[VALUE_W-1:0];
      end else begin
        d_lv <= bk[9].x[VALUE_W-1:0];
      end
    end
  end

  // ---------------------------------------------------------------------------------
  // Ratio: (|v| << FRAC_BITS) / |cmd|, one bit per stage; the output velocity rides along.
  // ---------------------------------------------------------------------------------
  vjal_ratio_div #(
    .NUM_W  (NUM_W),
    .DEN_W  (VALUE_W),
    .SIDE_W (VALUE_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (vld[10]),
    .num       ({d_mag, {FRAC_BITS{1'b0}}}),
    .den       (d_den),
    .in_flags  (d_flags),
    .side_in   (d_lv),
    .out_valid (div_valid),
    .quot      (div_quot),
    .out_flags (div_flags),
    .side_out  (div_lv)
  );

  // Saturate the quotient, apply the sign; a zero command gives exactly one.
  always_comb begin
    result.limited_velocity = div_lv;
    if (div_flags.zero) begin
      result.scale_ratio = RATIO_ONE;
    end else if (div_flags.neg) begin
      result.scale_ratio = (div_flags.ovf || (div_quot > RATIO_LIM))
                           ? (VALUE_W'(0) - RATIO_LIM) : (VALUE_W'(0) - div_quot);
    end else begin
      result.scale_ratio = (div_flags.ovf || (div_quot > RATIO_MAX)) ? RATIO_MAX : div_quot;
    end
  end

  // ---------------------------------------------------------------------------------
  // Output register with skid register behind it.
  // ---------------------------------------------------------------------------------
  assign pipe_emit = adv && div_valid;
  assign res_take  = res_valid && !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (res_take) begin
        skid_valid <= 1'b0;
      end
    end else if (pipe_emit) begin
      if (res_valid && !res_take) begin
        skid_valid <= 1'b1;
      end else begin
        res_valid <= 1'b1;
      end
    end else if (res_take) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (res_take) begin
        res_data <= skid_data;
      end
    end else if (pipe_emit) begin
      if (res_valid && !res_take) begin
        skid_data <= result;
      end else begin
        res_data <= result;
      end
    end
  end

endmodule

// ===== rtl/vjal_checker.sv =====
// Port-level checker for the velocity limiter, bound to the top level.
module vjal_checker
  import vjal_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input logic      clk,
  input logic      rst,
  input logic      cmd_stall,
  input logic      res_valid,
  input logic      res_stall,
  input vjal_out_t res_data
);

  localparam logic [VALUE_W-1:0] RATIO_ONE = VALUE_W'(1) << FRAC_BITS;

  // reset empties the output side and releases the input
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !res_valid && !cmd_stall)
    else $error("reset left an item or a stall behind");

  // the input only stalls while a finished item waits at the output
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    cmd_stall |-> res_valid)
    else $error("input stalled with no result waiting");

  // once the waiting item is taken the input is released next cycle
  a_stall_releases: assert property (@(posedge clk) disable iff (rst)
    cmd_stall && !res_stall |=> !cmd_stall)
    else $error("input stall held after the output drained");

  // a zero velocity gives a zero ratio, or one for a zero command
  a_zero_ratio: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_data.limited_velocity == '0)
      |-> (res_data.scale_ratio == '0) || (res_data.scale_ratio == RATIO_ONE))
    else $error("ratio inconsistent with zero velocity");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res_data))
    else $error("stalled result changed");

endmodule

bind velocity_jerk_accel_limiter_unit vjal_checker #(.FRAC_BITS(FRAC_BITS)) u_vjal_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_stall (cmd_stall),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res_data  (res_data)
);

// ===== sim/tb_velocity_jerk_accel_limiter_unit.sv =====
// Self-checking testbench for the velocity jerk/acceleration/velocity limiter unit.
module tb_velocity_jerk_accel_limiter_unit
  import vjal_pkg::*;
();

  localparam int FRAC_BITS       = 16;
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 129;
  localparam int LONG_HOLD       = 150;            // receiver hold-off, well past the depth
  localparam int DRAIN_CYCLES    = VALUE_W + 32;   // extra wait for stray results after the drain
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int MAX_PRINTS      = 40;

  // All-ones index lies past the last register and must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = {CFG_IDX_W{1'b1}};

  typedef enum bit {ROW_CFG, ROW_ITEM} row_kind_t;

  // How the random phases choose their lower and upper bounds
  typedef enum int {BOUNDS_NARROW, BOUNDS_WIDE, BOUNDS_EXTREME, BOUNDS_INVERTED} bounds_style_t;

  typedef struct {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [VALUE_W-1:0]   reg_val;
    vjal_in_t             item;
    bit                   typed;
    vjal_out_t            want;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cmd_valid;
  logic                 cmd_stall;
  vjal_in_t             cmd_data;
  logic                 res_valid;
  logic                 res_stall;
  vjal_out_t            res_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [VALUE_W-1:0]   cfg_data;

  // Shadow of the limit registers, updated on every accepted write
  logic [ENA_W-1:0]   ena_shadow = '0;
  logic signed [63:0] vel_lo = '0, vel_hi = '0;
  logic signed [63:0] acc_lo = '0, acc_hi = '0;
  logic signed [63:0] jerk_lo = '0, jerk_hi = '0;

  vjal_out_t pending_results[$];   // limited velocity and ratio still owed by the block
  stim_row_t rows[$];
  int        fail_count = 0;
  int        idle_cycles = 0;
  bit        tx_gapless = 1'b0;
  bit        rx_gapless = 1'b0;
  bit        long_hold_req = 1'b0;

  always #1 clk = ~clk;

  velocity_jerk_accel_limiter_unit #(.FRAC_BITS(FRAC_BITS)) dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_data  (cmd_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Predictor of the limiter, kept in 64-bit signed intermediates
  // ---------------------------------------------------------------------------

  function automatic logic signed [63:0] to_q64(input logic [VALUE_W-1:0] a);
    return {{(64 - VALUE_W){a[VALUE_W-1]}}, a};
  endfunction

  function automatic logic [63:0] abs_mag(input logic signed [63:0] a);
    return a[63] ? -a : a;
  endfunction

  // Bound times a Q.24 factor, truncated toward zero, pinned to +-2^62
  function automatic logic signed [63:0] scaled_bound(input logic signed [63:0] bound,
                                                      input logic [63:0] factor);
    logic [127:0] prod;
    prod = ({64'd0, abs_mag(bound)} * {64'd0, factor}) >> DT_FRAC;
    if (prod > {64'd0, BIG_MAG}) begin
      prod = {64'd0, BIG_MAG};
    end
    return bound[63] ? -$signed(prod[63:0]) : $signed(prod[63:0]);
  endfunction

  // Lower bound first, upper bound last: the upper one wins when they cross
  function automatic logic signed [63:0] clamp_hi_wins(input logic signed [63:0] x,
                                                       input logic signed [63:0] lo,
                                                       input logic signed [63:0] hi);
    logic signed [63:0] t;
    t = (x > lo) ? x : lo;
    return (t < hi) ? t : hi;
  endfunction

  function automatic logic signed [63:0] pin_to_2p62(input logic signed [63:0] x);
    if (x > $signed(BIG_MAG)) begin
      return $signed(BIG_MAG);
    end
    if (x < -$signed(BIG_MAG)) begin
      return -$signed(BIG_MAG);
    end
    return x;
  endfunction

  // limited / commanded in Q.FRAC_BITS, truncated toward zero and saturated
  function automatic logic [VALUE_W-1:0] ratio_q(input logic signed [63:0] num,
                                                 input logic signed [63:0] den);
    logic [127:0] q;
    logic [127:0] neg_q;
    logic [127:0] pos_lim;
    pos_lim = 128'd1 << (VALUE_W - 1);
    if (den == 0) begin
      return VALUE_W'(1) << FRAC_BITS;
    end
    q = ({64'd0, abs_mag(num)} << FRAC_BITS) / {64'd0, abs_mag(den)};
    if (num[63] != den[63]) begin
      if (q > pos_lim) begin
        q = pos_lim;
      end
      neg_q = -q;
      return neg_q[VALUE_W-1:0];
    end
    if (q > pos_lim - 1) begin
      q = pos_lim - 1;
    end
    return q[VALUE_W-1:0];
  endfunction

  function automatic vjal_out_t predict_limit(input vjal_in_t it);
    logic signed [63:0] cmd, last, older, v;
    logic [63:0]        dt, dt_sq2;
    vjal_out_t          r;
    cmd   = to_q64(it.cmd_velocity);
    last  = to_q64(it.last_velocity);
    older = to_q64(it.older_velocity);
    dt    = {32'd0, it.time_step};
    v     = cmd;
    // Jerk: bound the second difference by jerk * 2 * dt^2
    if (ena_shadow[ENA_JERK]) begin
      dt_sq2 = (dt * dt) >> (DT_FRAC - 1);
      v = pin_to_2p62(last + (last - older)
                      + clamp_hi_wins((v - last) - (last - older),
                                      scaled_bound(jerk_lo, dt_sq2),
                                      scaled_bound(jerk_hi, dt_sq2)));
    end
    // Acceleration: bound the first difference by accel * dt
    if (ena_shadow[ENA_ACC]) begin
      v = pin_to_2p62(last + clamp_hi_wins(v - last, scaled_bound(acc_lo, dt),
                                           scaled_bound(acc_hi, dt)));
    end
    if (ena_shadow[ENA_VEL]) begin
      v = clamp_hi_wins(v, vel_lo, vel_hi);
    end
    if (v > 64'sd2147483647) begin
      r.limited_velocity = 32'h7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      r.limited_velocity = 32'h8000_0000;
    end else begin
      r.limited_velocity = v[VALUE_W-1:0];
    end
    r.scale_ratio = ratio_q(v, cmd);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table helpers
  // ---------------------------------------------------------------------------

  function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [VALUE_W-1:0] val);
    stim_row_t r;
    r         = '{kind: ROW_CFG, default: '0};
    r.kind    = ROW_CFG;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic stim_row_t item_row(input logic [31:0] c, l, o, dt,
                                         input bit typed,
                                         input logic [31:0] lim, rat);
    stim_row_t r;
    r                     = '{kind: ROW_ITEM, default: '0};
    r.kind                = ROW_ITEM;
    r.item.cmd_velocity   = c;
    r.item.last_velocity  = l;
    r.item.older_velocity = o;
    r.item.time_step      = dt;
    r.typed               = typed;
    r.want.limited_velocity = lim;
    r.want.scale_ratio      = rat;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Reporting and handshakes
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (fail_count < MAX_PRINTS) begin
      $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    end
    fail_count++;
  endtask

  // Offer one item after a random gap; hold valid high until it is taken
  task automatic send_item(input vjal_in_t it, input bit typed, input vjal_out_t want);
    int gap;
    gap = tx_gapless ? 0 : $urandom_range(0, 9);
    @(negedge clk);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_data  <= it;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    pending_results.push_back(typed ? want : predict_limit(it));
  endtask

  // Drop valid and wait until every owed result has come back
  task automatic drain_results();
    @(negedge clk);
    cmd_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VALUE_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_LIMIT_ENABLES: ena_shadow = val[ENA_W-1:0];
      REG_VELOCITY_MIN:  vel_lo  = to_q64(val);
      REG_VELOCITY_MAX:  vel_hi  = to_q64(val);
      REG_ACCEL_MIN:     acc_lo  = to_q64(val);
      REG_ACCEL_MAX:     acc_hi  = to_q64(val);
      REG_JERK_MIN:      jerk_lo = to_q64(val);
      REG_JERK_MAX:      jerk_hi = to_q64(val);
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Random stimulus
  // ---------------------------------------------------------------------------

  task automatic pick_bounds(input bounds_style_t style, input int unsigned span,
                             output logic [31:0] lo, output logic [31:0] hi);
    case (style)
      BOUNDS_NARROW: begin
        lo = 32'd0 - $urandom_range(0, span);
        hi = $urandom_range(0, span);
      end
      BOUNDS_WIDE: begin
        lo = $urandom;
        hi = $urandom;
      end
      BOUNDS_EXTREME: begin
        // Full range, or the same extremes crossed over
        lo = 32'h8000_0000;
        hi = 32'h7FFF_FFFF;
        if ($urandom_range(0, 1) == 1) begin
          lo = 32'h7FFF_FFFF;
          hi = 32'h8000_0000;
        end
      end
      default: begin
        lo = $urandom_range(0, span);
        hi = 32'd0 - $urandom_range(0, span);
      end
    endcase
  endtask

  task automatic set_limits(input bounds_style_t style, input logic [ENA_W-1:0] ena);
    logic [VALUE_W-1:0] lo, hi, ena_word;
    // Junk in the upper bits must be dropped by the block
    ena_word = $urandom;
    ena_word[ENA_W-1:0] = ena;
    write_reg(REG_LIMIT_ENABLES, ena_word);
    pick_bounds(style, 1 << 20, lo, hi);
    write_reg(REG_VELOCITY_MIN, lo);
    write_reg(REG_VELOCITY_MAX, hi);
    pick_bounds(style, 1 << 20, lo, hi);
    write_reg(REG_ACCEL_MIN, lo);
    write_reg(REG_ACCEL_MAX, hi);
    pick_bounds(style, 1 << 19, lo, hi);
    write_reg(REG_JERK_MIN, lo);
    write_reg(REG_JERK_MAX, hi);
  endtask

  // Mostly plausible motion histories, so the clamps both engage and let go;
  // the rest is raw noise across every bit
  task automatic make_item(output vjal_in_t it);
    int base, step;
    if ($urandom_range(0, 3) == 0) begin
      it = {$urandom, $urandom, $urandom, $urandom};
    end else begin
      base = int'($urandom_range(0, 1 << 21)) - (1 << 20);
      step = int'($urandom_range(0, 1 << 17)) - (1 << 16);
      it.last_velocity  = base;
      it.older_velocity = base - step;
      it.cmd_velocity   = base + step + int'($urandom_range(0, 1 << 19)) - (1 << 18);
      it.time_step      = $urandom_range(1 << 12, 1 << 24);
      if ($urandom_range(0, 15) == 0) begin
        it.cmd_velocity = '0;
      end
      if ($urandom_range(0, 15) == 0) begin
        it.time_step = '0;
      end
      if ($urandom_range(0, 31) == 0) begin
        it.cmd_velocity = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall per item, long hold-off on request, check in order
  // ---------------------------------------------------------------------------

  initial begin : result_sink
    int        hold;
    vjal_out_t got;
    vjal_out_t want;
    res_stall = 1'b0;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      hold = rx_gapless ? 0 : $urandom_range(0, 9);
      if (long_hold_req) begin
        hold          = LONG_HOLD;
        long_hold_req = 1'b0;
      end
      if (hold > 0) begin
        res_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      res_stall <= 1'b0;
      @(posedge clk);
      while (!res_valid) @(posedge clk);
      got = res_data;
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", got.limited_velocity, '0);
      end else begin
        want = pending_results.pop_front();
        if (got.limited_velocity !== want.limited_velocity) begin
          report_mismatch("limited_velocity", got.limited_velocity, want.limited_velocity);
        end
        if (got.scale_ratio !== want.scale_ratio) begin
          report_mismatch("scale_ratio", got.scale_ratio, want.scale_ratio);
        end
      end
      @(negedge clk);
    end
  end

  // Abort if no channel moves an item for too long
  always @(posedge clk) begin
    if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("tb_velocity_jerk_accel_limiter_unit: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed table, random phases, drain, verdict
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    int            phase;
    int            n;
    vjal_in_t      it;
    bounds_style_t style;
    cmd_valid = 1'b0;
    cmd_data  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;

    // After reset every stage is off: the command passes through untouched
    rows.push_back(item_row(32'h0000_0000, 32'h1234_5678, 32'h8765_4321, 32'h0000_0000,
                            1'b1, 32'h0000_0000, 32'h0001_0000));
    rows.push_back(item_row(32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h0100_0000,
                            1'b1, 32'h7FFF_FFFF, 32'h0001_0000));
    rows.push_back(item_row(32'h8000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0100_0000,
                            1'b1, 32'h8000_0000, 32'h0001_0000));
    rows.push_back(item_row(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                            1'b1, 32'hFFFF_FFFF, 32'h0001_0000));
    // Velocity clamp to [-1.0, 1.0]
    rows.push_back(cfg_row(REG_LIMIT_ENABLES, 32'h0000_0001));
    rows.push_back(cfg_row(REG_VELOCITY_MIN, 32'hFFFF_0000));
    rows.push_back(cfg_row(REG_VELOCITY_MAX, 32'h0001_0000));
    rows.push_back(item_row(32'h0005_0000, 32'h0, 32'h0, 32'h0100_0000,
                            1'b1, 32'h0001_0000, 32'h0000_3333));
    rows.push_back(item_row(32'hFFFB_0000, 32'h0, 32'h0, 32'h0100_0000,
                            1'b1, 32'hFFFF_0000, 32'h0000_3333));
    rows.push_back(item_row(32'h0000_8000, 32'h0, 32'h0, 32'h0100_0000,
                            1'b1, 32'h0000_8000, 32'h0001_0000));
    // Crossed velocity bounds: the upper one, -2.0, always wins
    rows.push_back(cfg_row(REG_VELOCITY_MIN, 32'h0002_0000));
    rows.push_back(cfg_row(REG_VELOCITY_MAX, 32'hFFFE_0000));
    rows.push_back(item_row(32'h0001_0000, 32'h0, 32'h0, 32'h0100_0000,
                            1'b1, 32'hFFFE_0000, 32'hFFFE_0000));
    rows.push_back(item_row(32'h0000_0000, 32'h0, 32'h0, 32'h0100_0000,
                            1'b1, 32'hFFFE_0000, 32'h0001_0000));
    // A tiny command drives the ratio into negative saturation
    rows.push_back(item_row(32'h0000_0001, 32'h0, 32'h0, 32'h0100_0000,
                            1'b1, 32'hFFFE_0000, 32'h8000_0000));
    // Acceleration clamp to +-1.0 per second
    rows.push_back(cfg_row(REG_LIMIT_ENABLES, 32'h0000_0002));
    rows.push_back(cfg_row(REG_ACCEL_MIN, 32'hFFFF_0000));
    rows.push_back(cfg_row(REG_ACCEL_MAX, 32'h0001_0000));
    rows.push_back(item_row(32'h0005_0000, 32'h0, 32'h0, 32'h0100_0000,
                            1'b1, 32'h0001_0000, 32'h0000_3333));
    rows.push_back(item_row(32'h0006_0000, 32'h0003_0000, 32'h0, 32'h0000_0000,
                            1'b1, 32'h0003_0000, 32'h0000_8000));
    rows.push_back(item_row(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF,
                            1'b0, '0, '0));
    // Jerk alone: full-range bounds, then a zero band that forces overflow
    rows.push_back(cfg_row(REG_LIMIT_ENABLES, 32'h0000_0004));
    rows.push_back(cfg_row(REG_JERK_MIN, 32'h8000_0000));
    rows.push_back(cfg_row(REG_JERK_MAX, 32'h7FFF_FFFF));
    rows.push_back(item_row(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                            1'b0, '0, '0));
    rows.push_back(item_row(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001,
                            1'b0, '0, '0));
    rows.push_back(cfg_row(REG_JERK_MIN, 32'h0000_0000));
    rows.push_back(cfg_row(REG_JERK_MAX, 32'h0000_0000));
    rows.push_back(item_row(32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0100_0000,
                            1'b0, '0, '0));
    // Every stage on, extreme velocity and acceleration bounds
    rows.push_back(cfg_row(REG_LIMIT_ENABLES, 32'hFFFF_FFFF));
    rows.push_back(cfg_row(REG_VELOCITY_MIN, 32'h8000_0000));
    rows.push_back(cfg_row(REG_VELOCITY_MAX, 32'h7FFF_FFFF));
    rows.push_back(cfg_row(REG_ACCEL_MIN, 32'h8000_0000));
    rows.push_back(cfg_row(REG_ACCEL_MAX, 32'h7FFF_FFFF));
    rows.push_back(cfg_row(REG_JERK_MIN, 32'hFFF0_0000));
    rows.push_back(cfg_row(REG_JERK_MAX, 32'h0010_0000));
    rows.push_back(item_row(32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0100_0000, 1'b0, '0, '0));
    rows.push_back(item_row(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                            1'b0, '0, '0));
    rows.push_back(item_row(32'h0000_0000, 32'h0001_0000, 32'h0, 32'h0080_0000,
                            1'b0, '0, '0));
    // A write to the spare index must leave every limit as it was
    rows.push_back(cfg_row(REG_UNUSED, 32'h0000_0000));
    rows.push_back(item_row(32'h0002_0000, 32'h0001_0000, 32'h0, 32'h0100_0000,
                            1'b0, '0, '0));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Walk the directed table; hold register writes until the block is empty
    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        drain_results();
        write_reg(rows[i].reg_idx, rows[i].reg_val);
      end else begin
        send_item(rows[i].item, rows[i].typed, rows[i].want);
      end
    end

    // Random phases, each under fresh limits. Phase 2 sends back to back while the
    // receiver holds off, so the pipeline and skid fill and cmd_stall must rise;
    // phase 4 runs with no idling on either side; phase 5 pauses halfway until empty.
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      style = bounds_style_t'(phase % 4);
      drain_results();
      set_limits(style, (phase % 3 == 0) ? ENA_W'(7) : ENA_W'($urandom_range(0, 7)));
      tx_gapless = (phase == 2) || (phase == 4);
      rx_gapless = (phase == 4);
      if (phase == 2) begin
        long_hold_req = 1'b1;
      end
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (phase == 5 && n == ITEMS_PER_PHASE / 2) begin
          drain_results();
        end
        make_item(it);
        send_item(it, 1'b0, '0);
      end
    end

    // Wait out the owed results, then a little longer for any stray ones
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_velocity_jerk_accel_limiter_unit: PASS");
    end else begin
      $display("tb_velocity_jerk_accel_limiter_unit: FAIL");
    end
    $finish;
  end

endmodule
